@@ src/websocket_frame_receiver_unit_macros.svh @@
// Assertion macros used by the checker file of the frame receiver.
`ifndef WEBSOCKET_FRAME_RECEIVER_UNIT_MACROS_SVH
`define WEBSOCKET_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WSFR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define WSFR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/wsfr_pkg.sv @@
// Types and constants of the frame receiver.
package wsfr_pkg;

   // Frame opcodes that the parser tells apart.
   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;

   // Seven-bit length codes that announce an extended length.
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   // Extra header bytes after the first one of a field.
   localparam logic [2:0] EXT16_MORE = 3'd1;
   localparam logic [2:0] EXT64_MORE = 3'd7;
   localparam logic [2:0] MASK_MORE  = 3'd3;

   // Result stream kinds.
   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_PING  = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;

   // Queue between parser and output stage.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Parser phases.
   typedef enum logic [5:0] {
      PH_HDR0    = 6'b000001,
      PH_HDR1    = 6'b000010,
      PH_EXT     = 6'b000100,
      PH_MASK    = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_CLOSED  = 6'b100000
   } wsfr_phase_type;

   // One result as it travels from the parser to the output stage.
   typedef struct packed {
      logic [7:0] raw_byte;
      logic [7:0] key_byte;
      logic       unmask;
      logic       has_byte;
      logic [1:0] stream_kind;
      logic       message_start;
      logic       frame_end;
      logic       message_end;
   } wsfr_item_type;

endpackage

@@ src/wsfr_front.sv @@
// Frame parser: accepts stream bytes, tracks the header and classifies results.
module wsfr_front #(
   parameter int LENGTH_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   output logic                   push,
   output wsfr_pkg::wsfr_item_type item
);
   import wsfr_pkg::*;

   wsfr_phase_type         phase_ff, phase_in;
   logic                   fin_ff, fin_in;
   logic [3:0]             op_ff, op_in;
   logic                   mp_ff, mp_in;
   logic [2:0]             hbc_ff, hbc_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                   ovf_ff, ovf_in;
   logic [3:0][7:0]        key_ff, key_in;
   logic [1:0]             mi_ff, mi_in;
   logic                   asm_ff, asm_in;
   logic                   sp_ff, sp_in;

   logic                   hdr_done;
   logic                   begin_frame;
   logic                   emit_req;
   logic                   emit_has;
   logic                   emit_last;
   logic [LENGTH_BITS-1:0] len_shift;
   logic                   ovf_shift;

   // Extended length shifts in one byte; bits leaving the top mark an oversized length.
   assign len_shift = {len_ff[LENGTH_BITS-9:0], rx_byte};
   assign ovf_shift = ovf_ff | (len_ff[LENGTH_BITS-1:LENGTH_BITS-8] != 8'd0);

   // Next-state logic for one accepted byte.
   always_comb begin
      phase_in    = phase_ff;
      fin_in      = fin_ff;
      op_in       = op_ff;
      mp_in       = mp_ff;
      hbc_in      = hbc_ff;
      len_in      = len_ff;
      ovf_in      = ovf_ff;
      key_in      = key_ff;
      mi_in       = mi_ff;
      asm_in      = asm_ff;
      sp_in       = sp_ff;
      hdr_done    = 1'b0;
      begin_frame = 1'b0;
      emit_req    = 1'b0;
      emit_has    = 1'b0;
      emit_last   = 1'b0;
      push        = 1'b0;
      item        = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_HDR0: begin
               fin_in   = rx_byte[7];
               op_in    = rx_byte[3:0];
               mp_in    = 1'b0;
               hbc_in   = 3'd0;
               phase_in = PH_HDR1;
            end
            PH_HDR1: begin
               mp_in  = rx_byte[7];
               ovf_in = 1'b0;
               len_in = '0;
               if (rx_byte[6:0] == LEN7_EXT16) begin
                  hbc_in   = EXT16_MORE;
                  phase_in = PH_EXT;
               end else if (rx_byte[6:0] == LEN7_EXT64) begin
                  hbc_in   = EXT64_MORE;
                  phase_in = PH_EXT;
               end else begin
                  len_in   = LENGTH_BITS'(rx_byte[6:0]);
                  hdr_done = 1'b1;
               end
            end
            PH_EXT: begin
               ovf_in = ovf_shift;
               if (hbc_ff != 3'd0) begin
                  len_in = len_shift;
                  hbc_in = hbc_ff - 3'd1;
               end else begin
                  len_in   = ovf_shift ? '1 : len_shift;
                  hdr_done = 1'b1;
               end
            end
            PH_MASK: begin
               key_in = {key_ff[2:0], rx_byte};
               if (hbc_ff != 3'd0) begin
                  hbc_in = hbc_ff - 3'd1;
               end else begin
                  begin_frame = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               mi_in     = mi_ff + 2'd1;
               len_in    = len_ff - LENGTH_BITS'(1);
               emit_req  = 1'b1;
               emit_has  = 1'b1;
               emit_last = (len_ff == LENGTH_BITS'(1));
               if (emit_last) begin
                  phase_in = PH_HDR0;
               end
            end
            PH_CLOSED: begin
               phase_in = PH_CLOSED;
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase

         // Length known: a masking key follows, or the frame body starts.
         if (hdr_done) begin
            if (mp_in) begin
               hbc_in   = MASK_MORE;
               phase_in = PH_MASK;
            end else begin
               begin_frame = 1'b1;
            end
         end

         // Frame body starts; an empty frame gives its marker at once.
         if (begin_frame) begin
            mi_in = 2'd0;
            if (op_ff == OP_TEXT) begin
               asm_in = 1'b1;
               sp_in  = 1'b1;
            end
            if (len_in == '0) begin
               emit_req  = 1'b1;
               emit_last = 1'b1;
               phase_in  = PH_HDR0;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end

         // Route the result by opcode and message state.
         item.raw_byte = rx_byte;
         item.key_byte = key_ff[~mi_ff];
         item.unmask   = mp_ff;
         item.has_byte = emit_has;
         item.frame_end = emit_last;
         if (emit_req) begin
            priority if (op_ff == OP_CLOSE) begin
               if (emit_last) begin
                  push             = 1'b1;
                  item.has_byte    = 1'b0;
                  item.stream_kind = KIND_CLOSE;
                  phase_in         = PH_CLOSED;
                  asm_in           = 1'b0;
                  sp_in            = 1'b0;
               end
            end else if (op_ff == OP_PING) begin
               push             = 1'b1;
               item.stream_kind = KIND_PING;
            end else if (op_ff == OP_TEXT || (op_ff == OP_CONT && asm_in)) begin
               push               = 1'b1;
               item.stream_kind   = KIND_TEXT;
               item.message_start = sp_in;
               sp_in              = 1'b0;
               item.message_end   = emit_last & fin_ff;
               if (emit_last && fin_ff) begin
                  asm_in = 1'b0;
               end
            end
         end
      end
   end

   // Parser registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         asm_ff   <= 1'b0;
         sp_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         asm_ff   <= asm_in;
         sp_ff    <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
      op_ff  <= op_in;
      mp_ff  <= mp_in;
      hbc_ff <= hbc_in;
      len_ff <= len_in;
      ovf_ff <= ovf_in;
      key_ff <= key_in;
      mi_ff  <= mi_in;
   end

endmodule

@@ src/wsfr_queue.sv @@
// Short result queue between the parser and the output stage.
module wsfr_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  wsfr_pkg::wsfr_item_type push_item,
   input  logic                    pop,
   output logic                    full,
   output logic                    not_empty,
   output wsfr_pkg::wsfr_item_type head_item
);
   import wsfr_pkg::*;

   wsfr_item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];

   // Pointer and fill count update; wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ src/wsfr_back.sv @@
// Output stage: unmasks queued payload and holds the result for transfer.
module wsfr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_not_empty,
   input  wsfr_pkg::wsfr_item_type q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_data_byte,
   output logic                    rsp_has_byte,
   output logic [1:0]              rsp_stream_kind,
   output logic                    rsp_message_start,
   output logic                    rsp_frame_end,
   output logic                    rsp_message_end
);
   import wsfr_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       has_ff;
   logic [1:0] kind_ff;
   logic       ms_ff;
   logic       fe_ff;
   logic       me_ff;

   // Take the next entry whenever the output register is free or drains.
   assign q_pop = q_not_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   // Payload bytes are unmasked here; markers carry a zero byte.
   always_comb begin
      data_in = 8'd0;
      if (q_item.has_byte) begin
         data_in = q_item.unmask ? (q_item.raw_byte ^ q_item.key_byte) : q_item.raw_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff <= data_in;
         has_ff  <= q_item.has_byte;
         kind_ff <= q_item.stream_kind;
         ms_ff   <= q_item.message_start;
         fe_ff   <= q_item.frame_end;
         me_ff   <= q_item.message_end;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_data_byte     = data_ff;
   assign rsp_has_byte      = has_ff;
   assign rsp_stream_kind   = kind_ff;
   assign rsp_message_start = ms_ff;
   assign rsp_frame_end     = fe_ff;
   assign rsp_message_end   = me_ff;

endmodule

@@ src/websocket_frame_receiver_unit.sv @@
// Top level of the WebSocket frame receiver.
//
//   Channel  Direction  Handshake           Payload
//   req_     in         req_valid/req_stall req_rx_byte
//   rsp_     out        rsp_valid/rsp_stall data_byte, has_byte, stream_kind,
//                                           message_start, frame_end, message_end
//
// One byte is accepted per clock unless req_stall is high; the parser works combinationally.
// A result reaches rsp_ through the queue entry, written at the edge that transfers its byte,
// and then the output register, written when that register is free or drains.
// reset is synchronous and returns the parser to the first header byte.
// req_stall rises only when the two-entry queue is full, which takes a stalled rsp_ side.
// After a close notice every byte is accepted and dropped until reset.
module websocket_frame_receiver_unit #(
   parameter int LENGTH_BITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_has_byte,
   output logic [1:0] rsp_stream_kind,
   output logic       rsp_message_start,
   output logic       rsp_frame_end,
   output logic       rsp_message_end
);
   import wsfr_pkg::*;

   logic          accept;
   logic          push;
   wsfr_item_type push_item;
   logic          q_full;
   logic          q_not_empty;
   wsfr_item_type head_item;
   logic          q_pop;

   // A byte transfer completes when the queue has room.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   wsfr_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .push    (push),
      .item    (push_item)
   );

   wsfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   wsfr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_not_empty       (q_not_empty),
      .q_item            (head_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_stream_kind   (rsp_stream_kind),
      .rsp_message_start (rsp_message_start),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_message_end   (rsp_message_end)
   );

endmodule

@@ src/wsfr_checker.sv @@
// Port-level checks of the frame receiver and their binding to the top level.
`include "websocket_frame_receiver_unit_macros.svh"

module wsfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_has_byte,
   input logic [1:0] rsp_stream_kind,
   input logic       rsp_message_start,
   input logic       rsp_frame_end,
   input logic       rsp_message_end
);
   import wsfr_pkg::*;

   logic [13:0] rsp_word;
   logic        rsp_held;
   logic        rsp_marker;
   logic        rsp_close;
   logic        close_bare;
   logic        rsp_msg;
   logic        rsp_msg_end;

   // Terms that the checks below are built from.
   assign rsp_word    = {rsp_data_byte, rsp_has_byte, rsp_stream_kind, rsp_message_start,
                         rsp_frame_end, rsp_message_end};
   assign rsp_held    = rsp_valid && rsp_stall;
   assign rsp_marker  = rsp_valid && !rsp_has_byte;
   assign rsp_close   = rsp_valid && (rsp_stream_kind == KIND_CLOSE);
   assign close_bare  = rsp_frame_end && !rsp_has_byte && !rsp_message_start &&
                        !rsp_message_end;
   assign rsp_msg     = rsp_valid && (rsp_message_start || rsp_message_end);
   assign rsp_msg_end = rsp_valid && rsp_message_end;

   // A stalled result stays offered unchanged.
   `WSFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_word), "held result changed")

   // Markers without payload carry a zero byte.
   `WSFR_ASSERT_NOW(a_marker_zero, clock, reset, rsp_marker, rsp_data_byte == 8'd0, "nonzero marker byte")

   // A close notice is a bare frame end.
   `WSFR_ASSERT_NOW(a_close_shape, clock, reset, rsp_close, close_bare, "malformed close notice")

   // Message boundaries belong to text data only.
   `WSFR_ASSERT_NOW(a_msg_text, clock, reset, rsp_msg, rsp_stream_kind == KIND_TEXT, "message flag off text")

   // A message ends only on the last result of a frame.
   `WSFR_ASSERT_NOW(a_end_frame, clock, reset, rsp_msg_end, rsp_frame_end, "message end inside a frame")

endmodule

bind websocket_frame_receiver_unit wsfr_checker u_wsfr_checker (.*);
